/* hdl/fsa_pkg.sv */
package fsa_pkg;

    // datapath operation selects
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // n2/d2 <= input, acc <= input on the first word (sel S_ACC)
        OP_GCD_INIT,  // a <= x, b <= y (operands chosen by sel)
        OP_REM_START, // start a rem b
        OP_GCD_STEP,  // a <= b, b <= remainder
        OP_MUL,       // product <= x * y
        OP_DIV_START, // start x / y
        OP_SAVE,      // store quotient into selected temp
        OP_FINISH,    // acc update
        OP_OUT        // load output register
    } op_t;

    // operand selects
    localparam logic [2:0] S_D1D2  = 3'd0; // gcd(d1,d2) / d1*d2 / prod/g
    localparam logic [2:0] S_N1L   = 3'd1; // n1*lcd, /d1
    localparam logic [2:0] S_N2L   = 3'd2; // n2*lcd, /d2
    localparam logic [2:0] S_ACC   = 3'd3; // gcd(acc_num,acc_den), acc_num/g, acc load
    localparam logic [2:0] S_ACCD  = 3'd4; // acc_den/g
    localparam logic [2:0] S_LCD   = 3'd5; // save lcd

    typedef struct packed {
        op_t        op;
        logic [2:0] sel;
    } fsa_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic div_done;
        logic out_busy;
    } fsa_sts_t;

endpackage

/* hdl/fraction_sum_accumulator.sv */
// Fraction sum accumulator. Each input word carries one fraction; the first
// word of a run loads the running sum, later words are added over the least
// common denominator found by Euclid's gcd. The word with tlast set ends the
// run: the sum is reduced by gcd(num, den) and one output word is produced.
// All math wraps at WORD_WIDTH bits with C-style truncating division; any
// division by zero in a run gives an output of 0/0 with the error flag set.
// One shared restoring divider, one quotient bit per cycle, sets the rate.
// s_axis_tready is high only while the block is idle. A first word of a run
// is only loaded. A later word takes (gcd steps + 3) divides, and the word
// with tlast adds (gcd steps + 2) divides plus any wait for the previous
// output word to leave.
module fraction_sum_accumulator #(
    parameter int WORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] numerator, [63:32] denominator
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] sum_numerator, [63:32] sum_denominator
    output logic        m_axis_tuser    // div_error
);
    import fsa_pkg::*;

    fsa_cmd_t    cmd;
    fsa_sts_t    sts;
    logic [64:0] out_word;

    fsa_control u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
        .in_ready(s_axis_tready), .cmd(cmd), .sts(sts)
    );

    fsa_datapath #(.W(WORD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_num(s_axis_tdata[31:0]), .in_den(s_axis_tdata[63:32]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_word(out_word)
    );

    assign m_axis_tdata = out_word[63:0];
    assign m_axis_tuser = out_word[64];
endmodule

/* hdl/fsa_divider.sv */
module fsa_divider #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic         div_zero,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    // restoring divider on magnitudes, one quotient bit per cycle
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          sq_reg, sq_next;
    logic          sr_reg, sr_next;
    logic          z_reg, z_next;
    logic [W:0]    trial;
    logic [W:0]    sub;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sq_next   = sq_reg;
        sr_next   = sr_reg;
        z_next    = z_reg;
        trial     = {r_reg[W-1:0], q_reg[W-1]};
        sub       = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend[W-1] ? (~dividend + 1'b1) : dividend;
            d_next    = divisor[W-1] ? (~divisor + 1'b1) : divisor;
            r_next    = '0;
            cnt_next  = CW'(W);
            sq_next   = dividend[W-1] ^ divisor[W-1];
            sr_next   = dividend[W-1];
            z_next    = (divisor == '0);
            busy_next = (divisor != '0);
            done_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            if (!sub[W])
            begin
                r_next = sub;
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        sq_reg <= sq_next;
        sr_reg <= sr_next;
        z_reg  <= z_next;
    end

    assign done      = done_reg;
    assign div_zero  = z_reg;
    assign quotient  = z_reg ? '0 : (sq_reg ? (~q_reg + 1'b1) : q_reg);
    assign remainder = z_reg ? '0 :
                       (sr_reg ? (~r_reg[W-1:0] + 1'b1) : r_reg[W-1:0]);
endmodule

/* hdl/fsa_datapath.sv */
module fsa_datapath #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  fsa_pkg::fsa_cmd_t cmd,
    output fsa_pkg::fsa_sts_t sts,
    input  logic [31:0]      in_num,
    input  logic [31:0]      in_den,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [64:0]      out_word
);
    import fsa_pkg::*;

    logic [W-1:0] acc_num_reg, acc_den_reg, n2_reg, d2_reg;
    logic [W-1:0] ga_reg, gb_reg, p_reg, lcd_reg, t1_reg, t2_reg, rn_reg;
    logic         err_reg;
    logic         ov_reg;
    logic [64:0]  ow_reg;
    logic [W-1:0] dv_a, dv_b, mx, my;
    logic         dv_start, dv_done, dv_zero;
    logic [W-1:0] dv_q, dv_r;
    logic [W-1:0] n2w, d2w;
    logic [2*W-1:0] prod;

    assign n2w = W'($signed(in_num));
    assign d2w = W'($signed(in_den));

    always_comb
    begin
        mx = acc_den_reg;
        my = d2_reg;
        dv_a = p_reg;
        dv_b = ga_reg;
        unique case (cmd.sel)
            S_N1L:
            begin
                mx = acc_num_reg; my = lcd_reg; dv_a = p_reg; dv_b = acc_den_reg;
            end
            S_N2L:
            begin
                mx = n2_reg; my = lcd_reg; dv_a = p_reg; dv_b = d2_reg;
            end
            S_ACC:
            begin
                dv_a = acc_num_reg; dv_b = ga_reg;
            end
            S_ACCD:
            begin
                dv_a = acc_den_reg; dv_b = ga_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.op == OP_REM_START)
        begin
            dv_a = ga_reg;
            dv_b = gb_reg;
        end
    end

    assign dv_start = (cmd.op == OP_REM_START) || (cmd.op == OP_DIV_START);
    assign prod     = mx * my;

    fsa_divider #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b),
        .done(dv_done), .div_zero(dv_zero),
        .quotient(dv_q), .remainder(dv_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= '0;
            err_reg     <= 1'b0;
            ov_reg      <= 1'b0;
            ow_reg      <= '0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            if (dv_done && dv_zero)
                err_reg <= 1'b1;
            unique case (cmd.op)
                OP_LOAD:
                begin
                    // only the first word of a run replaces the sum
                    if (cmd.sel == S_ACC)
                    begin
                        acc_num_reg <= n2w;
                        acc_den_reg <= d2w;
                    end
                end
                OP_FINISH:
                begin
                    acc_num_reg <= t1_reg + t2_reg;
                    acc_den_reg <= lcd_reg;
                end
                OP_OUT:
                begin
                    ov_reg  <= 1'b1;
                    err_reg <= 1'b0;
                    if (err_reg)
                        ow_reg <= {1'b1, 64'd0};
                    else
                        ow_reg <= {1'b0, 32'(dv_q), 32'(rn_reg)};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                n2_reg <= n2w;
                d2_reg <= d2w;
            end
            OP_GCD_INIT:
            begin
                if (cmd.sel == S_ACC)
                begin
                    ga_reg <= acc_num_reg; gb_reg <= acc_den_reg;
                end
                else
                begin
                    ga_reg <= acc_den_reg; gb_reg <= d2_reg;
                end
            end
            OP_GCD_STEP:
            begin
                ga_reg <= gb_reg;
                gb_reg <= dv_r;
            end
            OP_MUL: p_reg <= prod[W-1:0];
            OP_SAVE:
            begin
                unique case (cmd.sel)
                    S_LCD:  lcd_reg <= dv_q;
                    S_N1L:  t1_reg  <= dv_q;
                    S_N2L:  t2_reg  <= dv_q;
                    default: rn_reg <= dv_q;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign sts.b_zero   = (gb_reg == '0);
    assign sts.div_done = dv_done;
    assign sts.out_busy = ov_reg;
    assign out_valid    = ov_reg;
    assign out_word     = ow_reg;
endmodule

/* hdl/fsa_control.sv */
module fsa_control (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output fsa_pkg::fsa_cmd_t cmd,
    input  fsa_pkg::fsa_sts_t sts
);
    import fsa_pkg::*;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_G1     = 5'd1;  // gcd(d1,d2) init
    localparam logic [4:0] ST_G1W    = 5'd2;
    localparam logic [4:0] ST_M1     = 5'd3;  // d1*d2
    localparam logic [4:0] ST_V1     = 5'd4;  // /g
    localparam logic [4:0] ST_V1W    = 5'd5;
    localparam logic [4:0] ST_M2     = 5'd6;
    localparam logic [4:0] ST_V2     = 5'd7;
    localparam logic [4:0] ST_V2W    = 5'd8;
    localparam logic [4:0] ST_M3     = 5'd9;
    localparam logic [4:0] ST_V3     = 5'd10;
    localparam logic [4:0] ST_V3W    = 5'd11;
    localparam logic [4:0] ST_ACC    = 5'd12;
    localparam logic [4:0] ST_LAST   = 5'd13;
    localparam logic [4:0] ST_G2     = 5'd14;
    localparam logic [4:0] ST_G2W    = 5'd15;
    localparam logic [4:0] ST_R1     = 5'd16;
    localparam logic [4:0] ST_R1W    = 5'd17;
    localparam logic [4:0] ST_R2     = 5'd18;
    localparam logic [4:0] ST_R2W    = 5'd19;
    localparam logic [4:0] ST_OUT    = 5'd20;
    localparam logic [4:0] ST_G1R    = 5'd21; // waiting on gcd remainder
    localparam logic [4:0] ST_FIN    = 5'd22; // sum update

    logic [4:0] state_reg, state_next;
    logic       started_reg, started_next;
    logic       last_reg, last_next;

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        last_next    = last_reg;
        cmd          = '{op: OP_NONE, sel: S_D1D2};
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op    = OP_LOAD;
                    last_next = in_last;
                    if (!started_reg)
                    begin
                        // first item of a run: the datapath loads acc via ACC path
                        cmd.sel      = S_ACC;
                        started_next = 1'b1;
                        state_next   = ST_ACC;
                    end
                    else
                    begin
                        state_next = ST_G1;
                    end
                end
            end
            ST_ACC:
            begin
                // first item: acc already loaded; n2/d2 stored too
                state_next = last_reg ? ST_LAST : ST_IDLE;
            end
            ST_G1:
            begin
                cmd = '{op: OP_GCD_INIT, sel: S_D1D2};
                state_next = ST_G1W;
            end
            ST_G1W:
            begin
                if (sts.b_zero)
                    state_next = ST_M1;
                else
                begin
                    cmd.op     = OP_REM_START;
                    state_next = ST_G1R;
                end
            end
            ST_G1R:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_GCD_STEP;
                    state_next = ST_G1W;
                end
            end
            ST_M1:
            begin
                cmd = '{op: OP_MUL, sel: S_D1D2};
                state_next = ST_V1;
            end
            ST_V1:
            begin
                cmd = '{op: OP_DIV_START, sel: S_D1D2};
                state_next = ST_V1W;
            end
            ST_V1W:
            begin
                if (sts.div_done)
                begin
                    cmd = '{op: OP_SAVE, sel: S_LCD};
                    state_next = ST_M2;
                end
            end
            ST_M2:
            begin
                cmd = '{op: OP_MUL, sel: S_N1L};
                state_next = ST_V2;
            end
            ST_V2:
            begin
                cmd = '{op: OP_DIV_START, sel: S_N1L};
                state_next = ST_V2W;
            end
            ST_V2W:
            begin
                if (sts.div_done)
                begin
                    cmd = '{op: OP_SAVE, sel: S_N1L};
                    state_next = ST_M3;
                end
            end
            ST_M3:
            begin
                cmd = '{op: OP_MUL, sel: S_N2L};
                state_next = ST_V3;
            end
            ST_V3:
            begin
                cmd = '{op: OP_DIV_START, sel: S_N2L};
                state_next = ST_V3W;
            end
            ST_V3W:
            begin
                if (sts.div_done)
                begin
                    cmd = '{op: OP_SAVE, sel: S_N2L};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.op     = OP_FINISH;
                state_next = last_reg ? ST_LAST : ST_IDLE;
            end
            ST_LAST:
            begin
                cmd = '{op: OP_GCD_INIT, sel: S_ACC};
                state_next = ST_G2;
            end
            ST_G2:
            begin
                if (sts.b_zero)
                    state_next = ST_R1;
                else
                begin
                    cmd.op     = OP_REM_START;
                    state_next = ST_G2W;
                end
            end
            ST_G2W:
            begin
                if (sts.div_done)
                begin
                    cmd.op     = OP_GCD_STEP;
                    state_next = ST_G2;
                end
            end
            ST_R1:
            begin
                cmd = '{op: OP_DIV_START, sel: S_ACC};
                state_next = ST_R1W;
            end
            ST_R1W:
            begin
                if (sts.div_done)
                begin
                    cmd = '{op: OP_SAVE, sel: S_ACC};
                    state_next = ST_R2;
                end
            end
            ST_R2:
            begin
                cmd = '{op: OP_DIV_START, sel: S_ACCD};
                state_next = ST_R2W;
            end
            ST_R2W:
            begin
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // quotient of the divider still holds the reduced denominator
                if (!sts.out_busy)
                begin
                    cmd.op       = OP_OUT;
                    started_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            last_reg    <= last_next;
        end
    end
endmodule
